// ===== design/gnrd_pkg.sv =====
// Package for the nibble run-length glyph decoder.
// Holds the sequencer and decode-mode types and fixed field constants.
// No dependencies.
package gnrd_pkg;

  // Fixed field widths
  localparam int CODE_BITS  = 4;
  localparam int ADDR_BITS  = 14;
  localparam int RUN_BITS   = 4;

  // A header below this value announces a run, otherwise a literal group
  localparam logic [CODE_BITS-1:0] RUN_HDR_LIMIT = 4'd8;
  // Literal group length is LIT_SPAN minus the header
  localparam logic [CODE_BITS:0]   LIT_SPAN      = 5'd16;

  // Configuration register indexes
  localparam int CFG_IDX_BITS = 2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GLYPH_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_GLYPH_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COLUMN_MAJOR = 2'd2;

  // What the next nibble means
  typedef enum logic [1:0] {
    MODE_HEADER  = 2'd0,
    MODE_RUN     = 2'd1,
    MODE_LITERAL = 2'd2
  } mode_t;

  // Pixel sequencer
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EMIT = 1'b1
  } state_t;

endpackage

// ===== design/glyph_nibble_rle_decoder.sv =====
// Top level of the nibble run-length glyph decoder.
// Depends on gnrd_pkg for types and constants.
//
//  channel | dir | handshake        | payload
//  in_     | in  | tvalid / tready  | tdata[3:0] code_nibble
//  out_    | out | tvalid / tready  | tdata[3:0] pixel_value, [17:4] pixel_address,
//          |     |                  | tlast last_of_run, tuser glyph_done
//  cfg_    | in  | we (no wait)     | addr register index, wdata register value
//
// A header nibble is accepted without yielding a pixel. A pixel-bearing nibble is accepted,
// then yields 1 to 8 pixels from the single pixel step unit, which emits one pixel and
// advances the address counters each cycle while the output register is free.
// A nibble whose glyph is already complete (or zero area) yields no pixel; the decode restarts.
// Output stalls hold the pixel step; one finished pixel waits in the output register.
// rst_n is synchronous, active low; it clears the configuration and control registers, counters and the mode.
module glyph_nibble_rle_decoder
  import gnrd_pkg::*;
#(
  parameter int DIM_BITS = 7
) (
  input  logic                    clk,
  input  logic                    rst_n,
  // input stream
  input  logic                    in_tvalid,
  output logic                    in_tready,
  input  logic [7:0]              in_tdata,   // [3:0] code_nibble, [7:4] zero
  // result stream
  output logic                    out_tvalid,
  input  logic                    out_tready,
  output logic [23:0]             out_tdata,  // [3:0] pixel_value, [17:4] pixel_address
  output logic                    out_tlast,  // last_of_run
  output logic                    out_tuser,  // [0] glyph_done
  // configuration
  input  logic                    cfg_we,
  input  logic [CFG_IDX_BITS-1:0] cfg_addr,
  input  logic [DIM_BITS-1:0]     cfg_wdata
);

  localparam int CW = 2 * DIM_BITS;
  localparam int AW = (CW > ADDR_BITS) ? CW : ADDR_BITS;

  // Configuration registers
  logic [DIM_BITS-1:0] width_r, height_r;
  logic                col_major_r;

  // Decode state
  state_t              state_r, state_nxt;
  mode_t               mode_r, mode_nxt;
  logic [RUN_BITS-1:0] lit_r, lit_nxt;
  logic [RUN_BITS-1:0] run_r, run_nxt;
  logic [RUN_BITS-1:0] rem_r, rem_nxt;
  logic [CODE_BITS-1:0] nib_r, nib_nxt;
  logic [CW-1:0]       pix_cnt_r, pix_cnt_nxt;
  logic [DIM_BITS-1:0] col_r, col_nxt;
  logic [DIM_BITS-1:0] row_r, row_nxt;
  logic [CW-1:0]       oaddr_r, oaddr_nxt;

  // Output register
  logic                 out_valid_r, out_valid_nxt;
  logic [CODE_BITS-1:0] out_pix_r, out_pix_nxt;
  logic [ADDR_BITS-1:0] out_addr_r, out_addr_nxt;
  logic                 out_last_r, out_last_nxt;
  logic                 out_done_r, out_done_nxt;

  // Pixel step signals
  logic                 in_fire;
  logic                 slot_free;
  logic                 step;
  logic                 stale;
  logic [CW-1:0]        len;
  logic [CW-1:0]        cnt_inc;
  logic [DIM_BITS-1:0]  row_inc, col_inc;
  logic [CW-1:0]        oaddr_inc;
  logic                 done;
  logic                 last;
  logic [AW-1:0]        addr_sel;
  logic [CODE_BITS-1:0] nib_in;

  assign nib_in    = in_tdata[CODE_BITS-1:0];
  assign in_tready = (state_r == ST_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;
  assign step      = (state_r == ST_EMIT) && slot_free;

  // Glyph area from the current registers
  assign len = CW'(width_r) * CW'(height_r);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r     <= '0;
      height_r    <= '0;
      col_major_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          CFG_GLYPH_WIDTH:  width_r     <= cfg_wdata;
          CFG_GLYPH_HEIGHT: height_r    <= cfg_wdata;
          CFG_COLUMN_MAJOR: col_major_r <= cfg_wdata[0];
          default: ;
        endcase
      end
    end
  end

  // Pixel step unit: one pixel and one counter advance per cycle while the output register is free
  always_comb begin
    stale     = (pix_cnt_r >= len);
    cnt_inc   = CW'(pix_cnt_r + 1'b1);
    row_inc   = DIM_BITS'(row_r + 1'b1);
    col_inc   = DIM_BITS'(col_r + 1'b1);
    oaddr_inc = CW'(oaddr_r + CW'(width_r));
    done      = (cnt_inc == len);
    last      = done || (rem_r == RUN_BITS'(1));
    addr_sel  = col_major_r ? AW'(oaddr_r) : AW'(pix_cnt_r);
  end

  // Sequencer: next state, mode and counters
  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    lit_nxt       = lit_r;
    run_nxt       = run_r;
    rem_nxt       = rem_r;
    nib_nxt       = nib_r;
    pix_cnt_nxt   = pix_cnt_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    oaddr_nxt     = oaddr_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_pix_nxt   = out_pix_r;
    out_addr_nxt  = out_addr_r;
    out_last_nxt  = out_last_r;
    out_done_nxt  = out_done_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          nib_nxt = nib_in;
          unique case (mode_r)
            MODE_RUN: begin
              rem_nxt   = RUN_BITS'(run_r + 1'b1);
              mode_nxt  = MODE_HEADER;
              state_nxt = ST_EMIT;
            end
            MODE_LITERAL: begin
              rem_nxt   = RUN_BITS'(1);
              lit_nxt   = RUN_BITS'(lit_r - 1'b1);
              if (lit_nxt == '0) mode_nxt = MODE_HEADER;
              state_nxt = ST_EMIT;
            end
            default: begin
              // header nibble: set up a run or a literal group
              if (nib_in < RUN_HDR_LIMIT) begin
                run_nxt  = nib_in;
                mode_nxt = MODE_RUN;
              end else begin
                lit_nxt  = RUN_BITS'(LIT_SPAN - {1'b0, nib_in});
                mode_nxt = MODE_LITERAL;
              end
            end
          endcase
        end
      end
      ST_EMIT: begin
        if (step) begin
          if (stale) begin
            // glyph already complete: drop the nibble and restart
            state_nxt   = ST_IDLE;
            mode_nxt    = MODE_HEADER;
            lit_nxt     = '0;
            pix_cnt_nxt = '0;
            col_nxt     = '0;
            row_nxt     = '0;
            oaddr_nxt   = '0;
          end else begin
            out_valid_nxt = 1'b1;
            out_pix_nxt   = nib_r;
            out_addr_nxt  = addr_sel[ADDR_BITS-1:0];
            out_last_nxt  = last;
            out_done_nxt  = done;
            rem_nxt       = RUN_BITS'(rem_r - 1'b1);
            if (done) begin
              state_nxt   = ST_IDLE;
              mode_nxt    = MODE_HEADER;
              lit_nxt     = '0;
              pix_cnt_nxt = '0;
              col_nxt     = '0;
              row_nxt     = '0;
              oaddr_nxt   = '0;
            end else begin
              if (last) state_nxt = ST_IDLE;
              pix_cnt_nxt = cnt_inc;
              // counters run in column order; wrap to the next column
              if (row_inc >= height_r) begin
                row_nxt   = '0;
                col_nxt   = col_inc;
                oaddr_nxt = CW'(col_inc);
              end else begin
                row_nxt   = row_inc;
                oaddr_nxt = oaddr_inc;
              end
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control and counter registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_HEADER;
      lit_r       <= '0;
      run_r       <= '0;
      rem_r       <= '0;
      pix_cnt_r   <= '0;
      col_r       <= '0;
      row_r       <= '0;
      oaddr_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      lit_r       <= lit_nxt;
      run_r       <= run_nxt;
      rem_r       <= rem_nxt;
      pix_cnt_r   <= pix_cnt_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      oaddr_r     <= oaddr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    nib_r      <= nib_nxt;
    out_pix_r  <= out_pix_nxt;
    out_addr_r <= out_addr_nxt;
    out_last_r <= out_last_nxt;
    out_done_r <= out_done_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_addr_r, out_pix_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  // Checks
  a_done_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_done_r |-> out_last_r)
    else $error("glyph_done beat without last_of_run");

  a_restart_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    step && !stale && done |=> pix_cnt_r == '0 && mode_r == MODE_HEADER)
    else $error("counters not cleared after glyph completion");

  a_emit_has_pixels: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_EMIT |-> rem_r != '0)
    else $error("pixel step with nothing left to emit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> $stable(out_addr_r) && $stable(out_pix_r))
    else $error("stalled result overwritten");

endmodule

// ===== tb/sv/glyph_nibble_rle_decoder_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for glyph_nibble_rle_decoder: streams code nibbles,
// predicts every decoded pixel beat and checks the pixel stream field by field.
// Depends on gnrd_pkg and the decoder RTL.
module glyph_nibble_rle_decoder_test
  import gnrd_pkg::*;
();

  localparam int DIM_W       = 7;
  localparam int HOLD_CYCLES = 16;   // covers the longest nibble with no pixel beat

  typedef struct packed {
    logic [3:0]           value;
    logic [ADDR_BITS-1:0] address;
    logic                 last_of_run;
    logic                 glyph_done;
  } pixel_t;

  logic                    clk        = 1'b0;
  logic                    rst_n      = 1'b0;
  logic                    in_tvalid  = 1'b0;
  logic                    in_tready;
  logic [7:0]              in_tdata   = '0;   // [3:0] code_nibble, [7:4] zero
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  logic [23:0]             out_tdata;         // [3:0] pixel_value, [17:4] pixel_address
  logic                    out_tlast;         // last_of_run
  logic                    out_tuser;         // [0] glyph_done
  logic                    cfg_we     = 1'b0;
  logic [CFG_IDX_BITS-1:0] cfg_addr   = CFG_GLYPH_WIDTH;
  logic [DIM_W-1:0]        cfg_wdata  = '0;

  // Run bookkeeping
  int failures       = 0;
  int nibbles_sent   = 0;
  int pixels_checked = 0;
  int settings_used  = 0;
  bit calm           = 1'b0;   // no idling on either side when set
  int stall_left     = 0;

  // Mirror of the registers and decoder state
  logic [DIM_W-1:0]     mir_width, mir_height;
  logic                 mir_column_major;
  mode_t                dec_mode;
  logic [3:0]           lit_left, run_len;
  logic [ADDR_BITS-1:0] pix_count, next_addr;
  logic [DIM_W-1:0]     col_idx, row_idx;
  pixel_t               pending_pixels[$];
  pixel_t               want;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  glyph_nibble_rle_decoder #(.DIM_BITS(DIM_W)) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // ---------------------------------------------------------------- predictor
  function automatic void restart_decode();
    dec_mode  = MODE_HEADER;
    lit_left  = '0;
    pix_count = '0;
    col_idx   = '0;
    row_idx   = '0;
    next_addr = '0;
  endfunction

  // Counters always walk in column order; next_addr is the transposed address
  function automatic void step_counters();
    pix_count = pix_count + 1'b1;
    row_idx   = row_idx + 1'b1;
    next_addr = next_addr + ADDR_BITS'(mir_width);
    if (row_idx >= mir_height) begin
      row_idx   = '0;
      col_idx   = col_idx + 1'b1;
      next_addr = ADDR_BITS'(col_idx);
    end
  endfunction

  function automatic void predict_nibble(input logic [3:0] nib);
    int unsigned          area;
    int unsigned          count;
    bit                   header;
    bit                   stop;
    logic [ADDR_BITS-1:0] addr;
    logic                 done;
    pixel_t               px;
    area   = int'(mir_width) * int'(mir_height);
    header = 1'b0;
    stop   = 1'b0;
    count  = 0;
    case (dec_mode)
      MODE_RUN: begin
        count    = run_len + 1;
        dec_mode = MODE_HEADER;
      end
      MODE_LITERAL: begin
        count    = 1;
        lit_left = lit_left - 1'b1;
        if (lit_left == 0) dec_mode = MODE_HEADER;
      end
      default: begin
        header = 1'b1;
        if (nib < RUN_HDR_LIMIT) begin
          run_len  = nib;
          dec_mode = MODE_RUN;
        end else begin
          lit_left = 4'(LIT_SPAN - nib);
          dec_mode = MODE_LITERAL;
        end
      end
    endcase
    if (!header) begin
      for (int k = 0; k < count && !stop; k++) begin
        // glyph already full (zero area or shrunk registers): restart, no beat
        if (pix_count >= area) begin
          restart_decode();
          stop = 1'b1;
        end else begin
          addr = mir_column_major ? next_addr : pix_count;
          step_counters();
          done           = (pix_count == area);
          px.value       = nib;
          px.address     = addr;
          px.last_of_run = done || (k + 1 == count);
          px.glyph_done  = done;
          pending_pixels.push_back(px);
          // early completion drops the rest of the run or group
          if (done) begin
            restart_decode();
            stop = 1'b1;
          end
        end
      end
    end
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("ERROR at %0t ns: %s got %0d expected %0d", $time, what, got, exp_val);
    failures++;
  endtask

  // Check each accepted pixel beat, then choose the next out_tready
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_pixels.size() == 0) begin
        report_mismatch("pixel beat with none pending, address", out_tdata[17:4], 0);
      end else begin
        want = pending_pixels.pop_front();
        if (out_tdata[3:0] != want.value)
          report_mismatch("pixel_value", out_tdata[3:0], want.value);
        if (out_tdata[17:4] != want.address)
          report_mismatch("pixel_address", out_tdata[17:4], want.address);
        if (out_tlast != want.last_of_run)
          report_mismatch("last_of_run", out_tlast, want.last_of_run);
        if (out_tuser != want.glyph_done)
          report_mismatch("glyph_done", out_tuser, want.glyph_done);
        pixels_checked++;
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 4);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  task automatic send_nibble(input logic [3:0] nib);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, nib};
    do @(posedge clk); while (!in_tready);
    predict_nibble(nib);
    nibbles_sent++;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every pending pixel, then let any silent nibble finish
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (HOLD_CYCLES) @(posedge clk);
  endtask

  task automatic set_glyph(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h,
                           input logic cm);
    drain();
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_GLYPH_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    mir_width = w;
    cfg_addr  <= CFG_GLYPH_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    mir_height = h;
    cfg_addr  <= CFG_COLUMN_MAJOR;
    cfg_wdata <= DIM_W'(cm);
    @(posedge clk);
    mir_column_major = cm;
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_run(input int len, input logic [3:0] value);
    send_nibble(4'(len - 1));
    send_nibble(value);
  endtask

  task automatic send_literals(input int n);
    send_nibble(4'(LIT_SPAN - n));
    repeat (n) send_nibble(4'($urandom_range(0, 15)));
  endtask

  // Mostly well-formed runs and literal groups, with some stray nibbles
  task automatic random_stream(input int n_items);
    int start;
    int pick;
    start = nibbles_sent;
    while (nibbles_sent - start < n_items) begin
      pick = $urandom_range(0, 9);
      if (pick < 5)      send_run($urandom_range(1, 8), 4'($urandom_range(0, 15)));
      else if (pick < 9) send_literals($urandom_range(1, 8));
      else               send_nibble(4'($urandom_range(0, 15)));
    end
  endtask

  // ---------------------------------------------------------------- tests
  // Registers still at reset (zero area), then width written as zero
  task automatic test_zero_area();
    send_run(4, 4'hF);
    send_nibble(4'd15);
    send_nibble(4'hA);
    set_glyph(7'd0, 7'd5, 1'b1);
    send_run(8, 4'h0);
  endtask

  // Shortest and longest run, early completion of a run and of a literal group
  task automatic test_row_major();
    set_glyph(7'd2, 7'd2, 1'b0);
    send_run(1, 4'h0);
    send_run(8, 4'hF);
    send_literals(8);
  endtask

  task automatic test_column_major();
    set_glyph(7'd2, 7'd3, 1'b1);
    send_literals(6);
  endtask

  // Order switched mid-glyph, then the glyph shrunk below the pixel count
  task automatic test_stale_count();
    set_glyph(7'd4, 7'd4, 1'b1);
    send_run(8, 4'h5);
    set_glyph(7'd4, 7'd4, 1'b0);
    send_run(2, 4'hA);
    set_glyph(7'd2, 7'd2, 1'b0);
    send_run(2, 4'h3);
  endtask

  task automatic test_random_glyphs();
    set_glyph(7'd127, 7'd127, 1'b1);
    random_stream(24);
    set_glyph(7'd1, 7'd1, 1'b0);
    random_stream(8);
    set_glyph(7'd127, 7'd1, 1'b1);
    random_stream(8);
    set_glyph(7'd1, 7'd127, 1'b0);
    random_stream(8);
    repeat (4) begin
      set_glyph(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
                1'($urandom_range(0, 1)));
      random_stream(8);
    end
    // last stretch runs flat out on both sides
    drain();
    calm = 1'b1;
    set_glyph(7'($urandom_range(1, 8)), 7'($urandom_range(1, 8)),
              1'($urandom_range(0, 1)));
    random_stream(20);
  endtask

  // ---------------------------------------------------------------- sequence
  initial begin
    mir_width        = '0;
    mir_height       = '0;
    mir_column_major = 1'b0;
    run_len          = '0;
    restart_decode();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_zero_area();
    test_row_major();
    test_column_major();
    test_stale_count();
    test_random_glyphs();
    drain();

    $display("%0d code nibbles sent, %0d pixel beats checked, %0d register settings",
             nibbles_sent, pixels_checked, settings_used);
    $display("zero area, early completion, stale count, order switch, both pixel orders");
    if (failures == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("timeout with %0d pixel beats still pending", pending_pixels.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
